/* rtl/core/btm_pkg.sv */
// Shared constants and types for the block-interpolating texture mapper.
// No dependencies; imported by btm_walker, btm_outq, the top level and the testbench.
`timescale 1ns / 1ps

package btm_pkg;

  // Block is (1 << BLK_LOG2) pixels on a side
  localparam int BLK_LOG2      = 3;
  localparam int BLOCK_SIZE    = 1 << BLK_LOG2;
  // Texel store is (1 << TEX_SIDE_BITS) texels on a side
  localparam int TEX_SIDE_BITS = 8;
  localparam int TEX_ADDR_W    = 2 * TEX_SIDE_BITS;
  localparam int TEX_DEPTH     = 1 << TEX_ADDR_W;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 8;
  localparam int POS_W   = 3;
  localparam int PIX_W   = 8;

  // Request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_RENDER = 1'b1;

  // Per-pixel tags that ride along with a texel read
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } btm_tag_t;

  // Texel read request from the walker
  typedef struct packed {
    logic                  valid;
    logic [TEX_ADDR_W-1:0] addr;
    btm_tag_t              tag;
  } btm_rd_req_t;

  // One finished result
  typedef struct packed {
    btm_tag_t         tag;
    logic [PIX_W-1:0] pixel;
  } btm_pix_t;

endpackage

/* rtl/core/btm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module btm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/btm_walker.sv */
// Coordinate walker: steps the block edges and rows and issues texel reads.
// Depends on btm_pkg.
`timescale 1ns / 1ps

module btm_walker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [btm_pkg::COORD_W-1:0] u_tl_i,
  input  logic signed [btm_pkg::COORD_W-1:0] v_tl_i,
  input  logic signed [btm_pkg::COORD_W-1:0] u_tr_i,
  input  logic signed [btm_pkg::COORD_W-1:0] v_tr_i,
  input  logic signed [btm_pkg::COORD_W-1:0] u_bl_i,
  input  logic signed [btm_pkg::COORD_W-1:0] v_bl_i,
  input  logic signed [btm_pkg::COORD_W-1:0] u_br_i,
  input  logic signed [btm_pkg::COORD_W-1:0] v_br_i,
  input  logic                             issue_ok_i,
  output logic                             busy_o,
  output btm_pkg::btm_rd_req_t             rd_o
);

  import btm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_EDGE,
    ST_ROW,
    ST_PIX
  } state_e;

  localparam logic [BLK_LOG2-1:0] CNT_MAX = BLK_LOG2'(BLOCK_SIZE - 1);

  state_e               state_q, state_d;
  logic [BLK_LOG2-1:0]  col_q, col_d;
  logic [BLK_LOG2-1:0]  row_q, row_d;

  // Edge positions: u left, v left, u right, v right
  logic [COORD_W-1:0]   pos_q  [4];
  // Bottom corners, then edge differences, then per-row edge steps
  logic [COORD_W-1:0]   edge_q [4];
  logic [COORD_W-1:0]   u_q, v_q, du_q, dv_q;
  logic                 issue;
  logic                 row_end;
  logic [COORD_W-1:0]   sh [4];

  assign issue   = (state_q == ST_PIX) && issue_ok_i;
  assign row_end = (col_q == CNT_MAX);

  // Truncating shift of the edge differences
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sh[i] = COORD_W'($signed(edge_q[i]) >>> BLK_LOG2);
      if (edge_q[i][COORD_W-1] && (edge_q[i][BLK_LOG2-1:0] != '0)) begin
        sh[i] = sh[i] + COORD_W'(1);
      end
    end
  end

  // Sequence control
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: state_d = ST_EDGE;
      ST_EDGE: begin
        state_d = ST_ROW;
        row_d   = '0;
      end
      ST_ROW: begin
        state_d = ST_PIX;
        col_d   = '0;
      end
      ST_PIX: begin
        if (issue) begin
          col_d = col_q + BLK_LOG2'(1);
          if (row_end) begin
            row_d   = row_q + BLK_LOG2'(1);
            state_d = (row_q == CNT_MAX) ? ST_IDLE : ST_ROW;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  // Coordinate datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          pos_q[0]  <= u_tl_i;
          pos_q[1]  <= v_tl_i;
          pos_q[2]  <= u_tr_i;
          pos_q[3]  <= v_tr_i;
          edge_q[0] <= u_bl_i;
          edge_q[1] <= v_bl_i;
          edge_q[2] <= u_br_i;
          edge_q[3] <= v_br_i;
        end
      end
      ST_DIFF: begin
        for (int i = 0; i < 4; i++) begin
          edge_q[i] <= edge_q[i] - pos_q[i];
        end
      end
      ST_EDGE: begin
        for (int i = 0; i < 4; i++) begin
          edge_q[i] <= sh[i];
        end
      end
      ST_ROW: begin
        u_q  <= pos_q[0];
        v_q  <= pos_q[1];
        du_q <= COORD_W'($signed(pos_q[2] - pos_q[0]) >>> BLK_LOG2);
        dv_q <= COORD_W'($signed(pos_q[3] - pos_q[1]) >>> BLK_LOG2);
      end
      ST_PIX: begin
        if (issue) begin
          u_q <= u_q + du_q;
          v_q <= v_q + dv_q;
          if (row_end) begin
            for (int i = 0; i < 4; i++) begin
              pos_q[i] <= pos_q[i] + edge_q[i];
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Read request for the current pixel
  always_comb begin
    rd_o.valid    = issue;
    rd_o.addr     = {v_q[FRAC_W +: TEX_SIDE_BITS], u_q[FRAC_W +: TEX_SIDE_BITS]};
    rd_o.tag.col  = POS_W'(col_q);
    rd_o.tag.row  = POS_W'(row_q);
    rd_o.tag.last = row_end && (row_q == CNT_MAX);
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* rtl/core/btm_outq.sv */
// Two-entry result queue between the texel store read port and the output.
// Depends on btm_pkg.
`timescale 1ns / 1ps

module btm_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  btm_pkg::btm_pix_t push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output btm_pkg::btm_pix_t data_o,
  output logic [1:0]        count_o
);

  import btm_pkg::*;

  btm_pix_t   entry_q [2];
  logic       rd_ptr_q, rd_ptr_d;
  logic       wr_ptr_q, wr_ptr_d;
  logic [1:0] count_q, count_d;

  // Advance pointers and occupancy
  always_comb begin
    rd_ptr_d = rd_ptr_q ^ pop_i;
    wr_ptr_d = wr_ptr_q ^ push_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store incoming results
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

/* rtl/core/block_interp_texture_mapper.sv */
// Top level of the block-interpolating affine texture mapper.
// Depends on btm_pkg, btm_ram, btm_walker and btm_outq.
`timescale 1ns / 1ps

// Usage
// The input channel carries two kinds of transfer. A load (req_type_i = 0)
// writes texel_value_i into the 256x256 texel store at texel_addr_i in the
// cycle it is accepted. A render (req_type_i = 1) carries four corner
// coordinates in signed 24.8 and yields 64 output transfers, row by row, each
// with its column, row and texel, last_o set on the 64th.
// A render walks edge set-up in the DIFF and EDGE states, then per row a ROW
// set-up state and one texel read per pixel; the single read port of the
// texel store sets the pixel rate in a row at one per cycle while the output
// queue has room. The first pixel passes through the registered texel read
// and then the output queue. in_stall_o is high while a render is being walked.
// A new item may enter while the last pixels of the previous render still
// drain from the two-entry output queue.
// With out_stall_i high, reads issue only while the output queue has room for
// them, so no result is lost. Reset clears all control state; the texel store
// keeps no reset value and must be loaded before it is rendered from.
module block_interp_texture_mapper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic [15:0]                  texel_addr_i,
  input  logic [7:0]                   texel_value_i,
  input  logic signed [31:0]           u_top_left_i,
  input  logic signed [31:0]           v_top_left_i,
  input  logic signed [31:0]           u_top_right_i,
  input  logic signed [31:0]           v_top_right_i,
  input  logic signed [31:0]           u_bottom_left_i,
  input  logic signed [31:0]           v_bottom_left_i,
  input  logic signed [31:0]           u_bottom_right_i,
  input  logic signed [31:0]           v_bottom_right_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   col_in_block_o,
  output logic [2:0]                   row_in_block_o,
  output logic [7:0]                   pixel_o,
  output logic                         last_o
);

  import btm_pkg::*;

  logic                  busy;
  logic                  in_xfer;
  logic                  load_we;
  logic                  start;
  logic                  issue_ok;
  logic                  pop;
  logic                  inflight_q;
  btm_tag_t              tag_q;
  btm_rd_req_t           rd_req;
  logic [PIX_W-1:0]      rd_data;
  btm_pix_t              push_data;
  btm_pix_t              head;
  logic [1:0]            q_count;

  // Input transfer decode
  assign in_stall_o = busy;
  assign in_xfer    = in_valid_i && !busy;
  assign load_we    = in_xfer && (req_type_i == REQ_LOAD);
  assign start      = in_xfer && (req_type_i == REQ_RENDER);

  // Issue a read only when the queue will have room for it
  assign pop      = out_valid_o && !out_stall_i;
  assign issue_ok = ((3'(q_count) + 3'(inflight_q)) < 3'd2) || pop;

  btm_walker u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .u_tl_i     (u_top_left_i),
    .v_tl_i     (v_top_left_i),
    .u_tr_i     (u_top_right_i),
    .v_tr_i     (v_top_right_i),
    .u_bl_i     (u_bottom_left_i),
    .v_bl_i     (v_bottom_left_i),
    .u_br_i     (u_bottom_right_i),
    .v_br_i     (v_bottom_right_i),
    .issue_ok_i (issue_ok),
    .busy_o     (busy),
    .rd_o       (rd_req)
  );

  btm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (TEX_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (TEX_ADDR_W'(texel_addr_i)),
    .wdata_i (texel_value_i),
    .re_i    (rd_req.valid),
    .raddr_i (rd_req.addr),
    .rdata_o (rd_data)
  );

  // Track the read in flight and its tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 1'b0;
    end else begin
      inflight_q <= rd_req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req.valid) begin
      tag_q <= rd_req.tag;
    end
  end

  assign push_data.tag   = tag_q;
  assign push_data.pixel = rd_data;

  btm_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (inflight_q),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .data_o      (head),
    .count_o     (q_count)
  );

  // Drive result fields from the queue head
  assign col_in_block_o = head.tag.col;
  assign row_in_block_o = head.tag.row;
  assign pixel_o        = head.pixel;
  assign last_o         = head.tag.last;

endmodule

/* bench/block_interp_texture_mapper_tb.sv */
// Self-checking testbench for block_interp_texture_mapper: loads texels and
// renders 8x8 blocks, predicting every output pixel. Depends on btm_pkg and block_interp_texture_mapper.
`timescale 1ns / 1ps

module block_interp_texture_mapper_tb;
  import btm_pkg::*;

  localparam int  PIX_PER_BLOCK = BLOCK_SIZE * BLOCK_SIZE;
  localparam int  TOTAL_ITEMS   = 180;
  localparam int  HOLD_AT_ITEM  = 110;
  localparam int  DRAIN_AT_ITEM = 150;
  localparam int  LONG_HOLD     = 300;
  localparam int  DRAIN_CYCLES  = 100;
  // Time limit for about 180 items and a few dozen renders under heavy output
  // stall
  localparam time RUN_LIMIT_NS  = 2_000_000;

  typedef struct {
    logic                  req_type;
    logic [TEX_ADDR_W-1:0] addr;
    logic [PIX_W-1:0]      value;
    logic [COORD_W-1:0]    u_tl, v_tl, u_tr, v_tr, u_bl, v_bl, u_br, v_br;
  } mapper_req_t;

  typedef struct {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } pixel_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE, RX_HEAVY} rx_mode_e;

  // Mirror of the texel store plus the queue of pixels still to come out
  class block_pixel_predictor;
    logic [PIX_W-1:0] texels [TEX_DEPTH];
    bit               written [TEX_DEPTH];
    pixel_t           pixels_due [$];
    int               mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Per-row step down an edge: wrapped difference, divided toward zero
    function logic [COORD_W-1:0] side_step(logic [COORD_W-1:0] hi, logic [COORD_W-1:0] lo);
      int d;
      d = int'(hi - lo);
      return d / BLOCK_SIZE;
    endfunction

    // Per-pixel step across a row: divided toward minus infinity
    function logic [COORD_W-1:0] span_step(logic [COORD_W-1:0] hi, logic [COORD_W-1:0] lo);
      int d;
      int q;
      d = int'(hi - lo);
      q = d / BLOCK_SIZE;
      if (d < 0 && (d % BLOCK_SIZE) != 0) q = q - 1;
      return q;
    endfunction

    // Texel address of every pixel of a block, in output order
    function void walk_block(input mapper_req_t it,
                             output logic [TEX_ADDR_W-1:0] addrs [PIX_PER_BLOCK]);
      logic [COORD_W-1:0] ul, vl, ur, vr, dul, dvl, dur, dvr, u, v, du, dv;
      ul  = it.u_tl;
      vl  = it.v_tl;
      ur  = it.u_tr;
      vr  = it.v_tr;
      dul = side_step(it.u_bl, ul);
      dvl = side_step(it.v_bl, vl);
      dur = side_step(it.u_br, ur);
      dvr = side_step(it.v_br, vr);
      for (int r = 0; r < BLOCK_SIZE; r++) begin
        u  = ul;
        v  = vl;
        du = span_step(ur, ul);
        dv = span_step(vr, vl);
        for (int c = 0; c < BLOCK_SIZE; c++) begin
          addrs[r * BLOCK_SIZE + c] = {v[FRAC_W +: TEX_SIDE_BITS], u[FRAC_W +: TEX_SIDE_BITS]};
          u = u + du;
          v = v + dv;
        end
        ul = ul + dul;
        vl = vl + dvl;
        ur = ur + dur;
        vr = vr + dvr;
      end
    endfunction

    // Apply one accepted input transfer
    function void take_transfer(mapper_req_t it);
      logic [TEX_ADDR_W-1:0] addrs [PIX_PER_BLOCK];
      pixel_t                p;
      if (it.req_type == REQ_LOAD) begin
        texels[it.addr]  = it.value;
        written[it.addr] = 1'b1;
      end else begin
        walk_block(it, addrs);
        for (int n = 0; n < PIX_PER_BLOCK; n++) begin
          p.col   = POS_W'(n % BLOCK_SIZE);
          p.row   = POS_W'(n / BLOCK_SIZE);
          p.pixel = texels[addrs[n]];
          p.last  = (n == PIX_PER_BLOCK - 1);
          pixels_due.push_back(p);
        end
      end
    endfunction

    function void compare_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Check one output transfer against the oldest expected pixel
    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel col %0d row %0d value %0h", $time,
                 got.col, got.row, got.pixel);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        compare_field("col_in_block", PIX_W'(want.col), PIX_W'(got.col));
        compare_field("row_in_block", PIX_W'(want.row), PIX_W'(got.row));
        compare_field("pixel", want.pixel, got.pixel);
        compare_field("last", PIX_W'(want.last), PIX_W'(got.last));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic [15:0]        texel_addr;
  logic [7:0]         texel_value;
  logic [31:0]        u_tl, v_tl, u_tr, v_tr, u_bl, v_bl, u_br, v_br;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         col_in_block;
  logic [2:0]         row_in_block;
  logic [7:0]         pixel;
  logic               last;

  block_pixel_predictor board = new();
  bit                   hold_off_req = 1'b0;
  int                   burst_left = 0;
  int                   items_sent = 0;

  block_interp_texture_mapper dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .texel_addr_i    (texel_addr),
    .texel_value_i   (texel_value),
    .u_top_left_i    (u_tl),
    .v_top_left_i    (v_tl),
    .u_top_right_i   (u_tr),
    .v_top_right_i   (v_tr),
    .u_bottom_left_i (u_bl),
    .v_bottom_left_i (v_bl),
    .u_bottom_right_i(u_br),
    .v_bottom_right_i(v_br),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .col_in_block_o  (col_in_block),
    .row_in_block_o  (row_in_block),
    .pixel_o         (pixel),
    .last_o          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every output transfer
  always @(posedge clk) begin
    pixel_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.col   = col_in_block;
      got.row   = row_in_block;
      got.pixel = pixel;
      got.last  = last;
      board.check_pixel(got);
    end
  end

  // Receiver stall pattern; a hold-off request stalls for a long counted stretch
  initial begin : rx_stall
    rx_mode_e mode;
    int       span;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(1, 40);
      repeat (span) begin
        case (mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_RANDOM: out_stall <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_stall <= ($urandom_range(0, 9) == 0);
          default:   out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("block_interp_texture_mapper_tb: done, errors");
    $finish;
  end

  // Offer one item in bursts with random gaps; hold it until the transfer
  task automatic send_item(mapper_req_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_type    <= it.req_type;
    texel_addr  <= it.addr;
    texel_value <= it.value;
    u_tl        <= it.u_tl;
    v_tl        <= it.v_tl;
    u_tr        <= it.u_tr;
    v_tr        <= it.v_tr;
    u_bl        <= it.u_bl;
    v_bl        <= it.v_bl;
    u_br        <= it.u_br;
    v_br        <= it.v_br;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.take_transfer(it);
    items_sent++;
  endtask

  function automatic mapper_req_t load_req(logic [15:0] addr, logic [7:0] value);
    mapper_req_t it;
    it.req_type = REQ_LOAD;
    it.addr     = addr;
    it.value    = value;
    it.u_tl = $urandom; it.v_tl = $urandom; it.u_tr = $urandom; it.v_tr = $urandom;
    it.u_bl = $urandom; it.v_bl = $urandom; it.u_br = $urandom; it.v_br = $urandom;
    return it;
  endfunction

  function automatic mapper_req_t render_req(logic [31:0] utl, vtl, utr, vtr,
                                             ubl, vbl, ubr, vbr);
    mapper_req_t it;
    it.req_type = REQ_RENDER;
    it.addr     = TEX_ADDR_W'($urandom);
    it.value    = PIX_W'($urandom);
    it.u_tl = utl; it.v_tl = vtl; it.u_tr = utr; it.v_tr = vtr;
    it.u_bl = ubl; it.v_bl = vbl; it.u_br = ubr; it.v_br = vbr;
    return it;
  endfunction

  // Block near a small pool of texel positions, corners within a few texels
  function automatic mapper_req_t local_render();
    logic [31:0] bu, bv;
    int          dxu, dxv, dyu, dyv;
    bu  = {16'($urandom), 8'($urandom_range(0, 7)), 8'($urandom)};
    bv  = {16'($urandom), 8'($urandom_range(0, 7)), 8'($urandom)};
    dxu = int'($urandom_range(0, 2048)) - 1024;
    dxv = int'($urandom_range(0, 2048)) - 1024;
    dyu = int'($urandom_range(0, 2048)) - 1024;
    dyv = int'($urandom_range(0, 2048)) - 1024;
    return render_req(bu, bv, bu + dxu, bv + dxv, bu + dyu, bv + dyv,
                      bu + dxu + dyu + int'($urandom_range(0, 256)) - 128,
                      bv + dxv + dyv + int'($urandom_range(0, 256)) - 128);
  endfunction

  // Write any texel the block will read that is still unwritten, then render
  task automatic render_block(mapper_req_t it);
    logic [TEX_ADDR_W-1:0] addrs [PIX_PER_BLOCK];
    board.walk_block(it, addrs);
    foreach (addrs[n]) begin
      if (!board.written[addrs[n]]) send_item(load_req(addrs[n], 8'($urandom)));
    end
    send_item(it);
  endtask

  initial begin : stimulus
    int pick;
    bit held;
    bit drained;
    held        = 1'b0;
    drained     = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    req_type    <= REQ_LOAD;
    texel_addr  <= '0;
    texel_value <= '0;
    u_tl <= '0; v_tl <= '0; u_tr <= '0; v_tr <= '0;
    u_bl <= '0; v_bl <= '0; u_br <= '0; v_br <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: address and value extremes, then corner cases of the walk
    send_item(load_req(16'h0000, 8'h00));
    send_item(load_req(16'hFFFF, 8'hFF));
    send_item(load_req(16'hAAAA, 8'h55));
    send_item(load_req(16'h5555, 8'hAA));
    render_block(render_req('0, '0, '0, '0, '0, '0, '0, '0));
    render_block(render_req('1, '1, '1, '1, '1, '1, '1, '1));
    // Differences that wrap across the signed limits
    render_block(render_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    // Negative differences where truncation and flooring disagree
    render_block(render_req(32'h0000_1000, 32'h0000_2000, 32'h0000_0F01, 32'h0000_2007,
                            32'h0000_0F01, 32'h0000_1F09, 32'h0000_0E03, 32'h0000_1F11));
    // Plain one-texel-per-pixel mapping
    render_block(render_req(32'h0, 32'h0, 32'h800, 32'h0,
                            32'h0, 32'h800, 32'h800, 32'h800));
    // Largest spans in both directions
    render_block(render_req(32'h8000_0000, 32'h7FFF_FF00, 32'h7FFF_FFFF, 32'h8000_0100,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(load_req(16'h0000, 8'hC3));
    render_block(render_req('0, '0, '0, '0, '0, '0, '0, '0));

    // Random: mostly local blocks, some wild ones, loads over old texels
    while (items_sent < TOTAL_ITEMS) begin
      if (!held && items_sent >= HOLD_AT_ITEM) begin
        // Stall the receiver and keep offering so the block backs up
        held         = 1'b1;
        hold_off_req = 1'b1;
        render_block(local_render());
        send_item(load_req(16'($urandom), 8'($urandom)));
      end
      if (held && !drained && items_sent >= DRAIN_AT_ITEM) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pixels_due.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_item(load_req(16'($urandom), 8'($urandom)));
      end else if (pick < 25) begin
        send_item(load_req({8'($urandom_range(0, 31)), 8'($urandom_range(0, 31))},
                           8'($urandom)));
      end else if (pick < 30) begin
        render_block(render_req($urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom));
      end else begin
        render_block(local_render());
      end
    end

    // Drain and finish
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pixels_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("block_interp_texture_mapper_tb: done, clean");
    end else begin
      $display("block_interp_texture_mapper_tb: done, errors");
    end
    $finish;
  end

endmodule
